// ----- src/tpsi_pkg.sv -----
// Shared types and constants for the two-point sample interpolator.
`timescale 1ns / 1ps
`default_nettype none

package tpsi_pkg;

    localparam int VALUE_BITS_DEF = 32;
    localparam int TIME_BITS_DEF  = 32;
    localparam int CFG_BITS       = 32;

    localparam logic [CFG_BITS-1:0] MAX_GAP_RESET = 32'd1000;

    localparam logic KIND_FEED  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic accept;    // input beat taken this cycle
        logic mul_step;  // one shift-add step of off * |diff|
        logic div_step;  // one restoring step of product / span
        logic out_load;  // move result into the output register
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic interp;    // the offered query needs the interpolation path
    } sts_t;

endpackage

`default_nettype wire

// ----- src/tpsi_ctrl.sv -----
// Controller: accepts beats, sequences multiply and divide steps, owns output valid.
`timescale 1ns / 1ps
`default_nettype none

module tpsi_ctrl #(
    parameter int VALUE_BITS = tpsi_pkg::VALUE_BITS_DEF
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire logic          s_kind,
    output logic               m_valid,
    input  wire logic          m_ready,
    input  wire tpsi_pkg::sts_t sts,
    output tpsi_pkg::cmd_t     cmd
);
    import tpsi_pkg::*;

    localparam int CNT_W = $clog2(VALUE_BITS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VALUE_BITS - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             m_valid_reg, m_valid_next;
    logic             out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg;
        cmd          = '0;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    if (s_kind == KIND_QUERY) begin
                        if (sts.interp) begin
                            state_next = ST_MUL;
                            cnt_next   = CNT_LAST;
                        end else begin
                            state_next = ST_FIN;
                        end
                    end
                end
            end
            ST_MUL: begin
                cmd.mul_step = 1'b1;
                cnt_next     = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = ST_DIV;
                    cnt_next   = CNT_LAST;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // a waiting result is never overwritten
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid_reg || m_ready))
        else $error("output register overwritten while a beat waits");

    // a feed beat keeps the controller in the idle state and gives no result
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_kind == KIND_FEED) |=> (state_reg == ST_IDLE))
        else $error("feed beat left the idle state");

    // the divide phase always starts with a full step count
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MUL && cnt_reg == '0) |=>
            (state_reg == ST_DIV && cnt_reg == CNT_LAST))
        else $error("divide phase started with wrong count");

    // a result appears only out of the finish state
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == ST_FIN))
        else $error("output valid rose outside the finish state");

endmodule

`default_nettype wire

// ----- src/tpsi_dp.sv -----
// Datapath: sample registers, case selection, shift-add multiply, restoring divide.
`timescale 1ns / 1ps
`default_nettype none

module tpsi_dp #(
    parameter int VALUE_BITS = tpsi_pkg::VALUE_BITS_DEF,
    parameter int TIME_BITS  = tpsi_pkg::TIME_BITS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [tpsi_pkg::CFG_BITS-1:0] cfg_wr_data,
    input  wire logic                          s_kind,
    input  wire logic [VALUE_BITS-1:0]         s_sample_value,
    input  wire logic [TIME_BITS-1:0]          s_time_stamp,
    output logic [VALUE_BITS-1:0]              m_estimate,
    output logic                               m_in_span,
    input  wire tpsi_pkg::cmd_t                cmd,
    output tpsi_pkg::sts_t                     sts
);
    import tpsi_pkg::*;

    localparam int AW = TIME_BITS + VALUE_BITS;             // product / divide register
    localparam int GW = (TIME_BITS > CFG_BITS) ? TIME_BITS : CFG_BITS;
    localparam logic [GW-1:0] TMASK = GW'({TIME_BITS{1'b1}});

    logic                  have_older_reg, have_newer_reg;
    logic [VALUE_BITS-1:0] older_value_reg, newer_value_reg;
    logic [TIME_BITS-1:0]  older_time_reg, newer_time_reg;
    logic [CFG_BITS-1:0]   max_gap_reg;

    logic                  interp_reg;
    logic [VALUE_BITS-1:0] res_value_reg;
    logic                  res_span_reg;
    logic [TIME_BITS-1:0]  off_reg;
    logic [VALUE_BITS-1:0] mag_reg;
    logic                  neg_reg;
    logic [AW-1:0]         acc_reg;
    logic [VALUE_BITS-1:0] m_estimate_reg;
    logic                  m_in_span_reg;

    // query decision
    logic [TIME_BITS-1:0]  span;
    logic [GW-1:0]         span_w, gap_w;
    logic [VALUE_BITS-1:0] q_value;
    logic                  q_span, q_interp;
    logic [VALUE_BITS:0]   diff;
    logic [VALUE_BITS:0]   diff_abs;

    // divide step
    logic [TIME_BITS:0]    trial, trial_sub;
    logic                  ge;

    logic [VALUE_BITS-1:0] quot, est;

    assign span   = newer_time_reg - older_time_reg;
    assign span_w = GW'(span);
    assign gap_w  = GW'(max_gap_reg) & TMASK;

    always_comb begin
        q_value  = older_value_reg;
        q_span   = 1'b0;
        q_interp = 1'b0;
        if (!have_older_reg) begin
            q_value = '0;
        end else if (!have_newer_reg || s_time_stamp > newer_time_reg) begin
            q_value = have_newer_reg ? newer_value_reg : older_value_reg;
        end else if (s_time_stamp <= older_time_reg) begin
            q_span = 1'b1;
        end else if (newer_time_reg <= older_time_reg || span_w > gap_w) begin
            q_span = 1'b0;
        end else begin
            q_span   = 1'b1;
            q_interp = 1'b1;
        end
    end

    assign sts.interp = q_interp;

    assign diff = {newer_value_reg[VALUE_BITS-1], newer_value_reg}
                - {older_value_reg[VALUE_BITS-1], older_value_reg};
    assign diff_abs = diff[VALUE_BITS] ? (~diff + 1'b1) : diff;

    // remainder sits in the upper bits, next numerator bit just below it
    assign trial     = {acc_reg[AW-1:VALUE_BITS], acc_reg[VALUE_BITS-1]};
    assign trial_sub = trial - {1'b0, span};
    assign ge        = !trial_sub[TIME_BITS];

    assign quot = acc_reg[VALUE_BITS-1:0];
    assign est  = neg_reg ? (older_value_reg - quot) : (older_value_reg + quot);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_older_reg <= 1'b0;
            have_newer_reg <= 1'b0;
            max_gap_reg    <= MAX_GAP_RESET;
            interp_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                max_gap_reg <= cfg_wr_data;
            end
            if (cmd.accept && s_kind == KIND_FEED) begin
                if (!have_older_reg) begin
                    have_older_reg <= 1'b1;
                end else begin
                    have_newer_reg <= 1'b1;
                end
            end
            if (cmd.accept && s_kind == KIND_QUERY) begin
                interp_reg <= q_interp;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            if (s_kind == KIND_FEED) begin
                if (!have_older_reg) begin
                    older_value_reg <= s_sample_value;
                    older_time_reg  <= s_time_stamp;
                end else begin
                    if (have_newer_reg) begin
                        older_value_reg <= newer_value_reg;
                        older_time_reg  <= newer_time_reg;
                    end
                    newer_value_reg <= s_sample_value;
                    newer_time_reg  <= s_time_stamp;
                end
            end else begin
                res_value_reg <= q_value;
                res_span_reg  <= q_span;
                off_reg       <= s_time_stamp - older_time_reg;
                mag_reg       <= diff_abs[VALUE_BITS-1:0];
                neg_reg       <= diff[VALUE_BITS];
                acc_reg       <= '0;
            end
        end
        if (cmd.mul_step) begin
            acc_reg <= (acc_reg << 1) + (mag_reg[VALUE_BITS-1] ? AW'(off_reg) : '0);
            mag_reg <= mag_reg << 1;
        end
        if (cmd.div_step) begin
            acc_reg <= {(ge ? trial_sub[TIME_BITS-1:0] : trial[TIME_BITS-1:0]),
                        acc_reg[VALUE_BITS-2:0], ge};
        end
        if (cmd.out_load) begin
            m_estimate_reg <= interp_reg ? est : res_value_reg;
            m_in_span_reg  <= res_span_reg;
        end
    end

    assign m_estimate = m_estimate_reg;
    assign m_in_span  = m_in_span_reg;

endmodule

`default_nettype wire

// ----- src/two_point_sample_interpolator.sv -----
// Top level of the two-point sample interpolator.
//
//  channel  direction  handshake          payload
//  s_       in         s_valid / s_ready  s_kind, s_sample_value, s_time_stamp
//  m_       out        m_valid / m_ready  m_estimate, m_in_span
//  cfg_     in         cfg_wr_en          cfg_wr_data (max_gap)
//
// A feed beat only updates the sample store and gives no result. A query that needs
// interpolation runs VALUE_BITS shift-add steps of the multiplier, then VALUE_BITS
// steps of the restoring divider, then the finish state; other queries go straight to it.
// Reset is synchronous, active low, and empties the sample store; max_gap returns to 1000.
// A new beat is taken while the previous result waits in the output register;
// a finished query waits in its last state until that register is free.
`timescale 1ns / 1ps
`default_nettype none

module two_point_sample_interpolator #(
    parameter int VALUE_BITS = tpsi_pkg::VALUE_BITS_DEF,
    parameter int TIME_BITS  = tpsi_pkg::TIME_BITS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [tpsi_pkg::CFG_BITS-1:0] cfg_wr_data,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_kind,
    input  wire logic signed [VALUE_BITS-1:0]  s_sample_value,
    input  wire logic [TIME_BITS-1:0]          s_time_stamp,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic signed [VALUE_BITS-1:0]       m_estimate,
    output logic                               m_in_span
);
    import tpsi_pkg::*;

    cmd_t                  cmd;
    sts_t                  sts;
    logic [VALUE_BITS-1:0] estimate;

    tpsi_ctrl #(
        .VALUE_BITS(VALUE_BITS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_kind  (s_kind),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    tpsi_dp #(
        .VALUE_BITS(VALUE_BITS),
        .TIME_BITS (TIME_BITS)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_kind         (s_kind),
        .s_sample_value (s_sample_value),
        .s_time_stamp   (s_time_stamp),
        .m_estimate     (estimate),
        .m_in_span      (m_in_span),
        .cmd            (cmd),
        .sts            (sts)
    );

    assign m_estimate = estimate;

endmodule

`default_nettype wire

// ----- dv/two_point_sample_interpolator_tb.sv -----
// Self-checking testbench for the two-point sample interpolator.
`timescale 1ns / 1ps

module two_point_sample_interpolator_tb;

    import tpsi_pkg::*;

    localparam int VB = VALUE_BITS_DEF;
    localparam int TB = TIME_BITS_DEF;
    localparam logic [TB-1:0] T_MAX = '1;
    localparam logic signed [VB-1:0] V_MIN = {1'b1, {(VB-1){1'b0}}};
    localparam logic signed [VB-1:0] V_MAX = {1'b0, {(VB-1){1'b1}}};
    // covers the longest query, multiply and divide steps, with margin after the last result
    localparam int SETTLE_CYCLES = 2 * VB + 20;

    typedef struct packed {
        logic signed [VB-1:0] estimate;
        logic                 in_span;
    } estimate_t;

    logic                        aclk;
    logic                        aresetn;
    logic                        cfg_wr_en;
    logic [CFG_BITS-1:0]         cfg_wr_data;
    logic                        s_valid;
    logic                        s_ready;
    logic                        s_kind;
    logic signed [VB-1:0]        s_sample_value;
    logic [TB-1:0]               s_time_stamp;
    logic                        m_valid;
    logic                        m_ready;
    logic signed [VB-1:0]        m_estimate;
    logic                        m_in_span;

    two_point_sample_interpolator #(
        .VALUE_BITS(VB),
        .TIME_BITS (TB)
    ) i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_sample_value(s_sample_value),
        .s_time_stamp  (s_time_stamp),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_estimate    (m_estimate),
        .m_in_span     (m_in_span)
    );

    // sample store as the block should hold it
    logic                 have_older;
    logic                 have_newer;
    logic signed [VB-1:0] older_value;
    logic signed [VB-1:0] newer_value;
    logic [TB-1:0]        older_time;
    logic [TB-1:0]        newer_time;
    logic [TB-1:0]        gap_limit;

    estimate_t pending_estimates[$];
    int        fail_count;
    logic      burst_mode;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #4_000_000;
        $display("two_point_sample_interpolator_tb NOT OK");
        $finish;
    end

    function automatic estimate_t predict_estimate(input logic [TB-1:0] ts);
        estimate_t          r;
        logic [TB-1:0]      dt;
        logic [TB-1:0]      off;
        logic signed [VB:0] diff;
        logic [VB:0]        mag;
        logic [VB+TB:0]     prod;
        logic [VB+TB:0]     quo;
        r.estimate = '0;
        r.in_span  = 1'b0;
        if (!have_older) begin
            r.estimate = '0;
        end else if (!have_newer || ts > newer_time) begin
            r.estimate = have_newer ? newer_value : older_value;
        end else if (ts <= older_time) begin
            r.estimate = older_value;
            r.in_span  = 1'b1;
        end else if (newer_time <= older_time || newer_time - older_time > gap_limit) begin
            r.estimate = older_value;
        end else begin
            dt   = newer_time - older_time;
            off  = ts - older_time;
            diff = $signed({newer_value[VB-1], newer_value})
                 - $signed({older_value[VB-1], older_value});
            mag  = diff[VB] ? -diff : diff;
            prod = off * mag;
            quo  = prod / dt;
            // quotient truncates toward zero, then the sign of the slope is applied
            r.estimate = diff[VB] ? older_value - quo[VB-1:0] : older_value + quo[VB-1:0];
            r.in_span  = 1'b1;
        end
        return r;
    endfunction

    task automatic record_beat(input logic kind, input logic signed [VB-1:0] value,
                               input logic [TB-1:0] ts);
        if (kind == KIND_QUERY) begin
            pending_estimates.push_back(predict_estimate(ts));
        end else if (!have_older) begin
            older_value = value;
            older_time  = ts;
            have_older  = 1'b1;
        end else begin
            if (have_newer) begin
                older_value = newer_value;
                older_time  = newer_time;
            end
            newer_value = value;
            newer_time  = ts;
            have_newer  = 1'b1;
        end
    endtask

    // valid is left high after the beat; drain_results, or a next call that waits first, lowers it
    task automatic send_item(input logic kind, input logic signed [VB-1:0] value,
                             input logic [TB-1:0] ts);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_kind         <= kind;
        s_sample_value <= value;
        s_time_stamp   <= ts;
        do @(posedge aclk); while (!s_ready);
        record_beat(kind, value, ts);
    endtask

    task automatic feed(input logic signed [VB-1:0] value, input logic [TB-1:0] ts);
        send_item(KIND_FEED, value, ts);
    endtask

    task automatic query(input logic [TB-1:0] ts);
        send_item(KIND_QUERY, $urandom(), ts);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_estimates.size() != 0) @(posedge aclk);
        // a trailing feed may still be in flight
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_max_gap(input logic [CFG_BITS-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        gap_limit    = value[TB-1:0];
    endtask

    // result side: random back-pressure outside burst mode, compare each beat with the oldest prediction
    initial begin
        int        stall;
        estimate_t want;
        m_ready = 1'b0;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            stall = burst_mode ? 0 : $urandom_range(0, 3);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            if (pending_estimates.size() == 0) begin
                $display("%0t: unexpected result beat estimate %h in_span %b",
                         $time, m_estimate, m_in_span);
                fail_count++;
            end else begin
                want = pending_estimates.pop_front();
                if (m_estimate !== want.estimate) begin
                    $display("%0t: estimate expected %h actual %h",
                             $time, want.estimate, m_estimate);
                    fail_count++;
                end
                if (m_in_span !== want.in_span) begin
                    $display("%0t: in_span expected %b actual %b",
                             $time, want.in_span, m_in_span);
                    fail_count++;
                end
            end
        end
    end

    task automatic test_empty_store();
        query('0);
        query(T_MAX);
    endtask

    task automatic test_single_sample();
        feed(V_MIN, 32'd100);
        query(32'd50);
        query(32'd100);
        query(T_MAX);
    endtask

    task automatic test_span_cases();
        feed(V_MAX, 32'd600);
        query(32'd601);  // past the newer sample
        query(32'd100);  // at the older time
        query(32'd0);    // before the older time
        query(32'd101);
        query(32'd350);
        query(32'd600);
        feed(32'sd12345, 32'd600);  // empty span
        query(32'd600);
        feed(-32'sd777, 32'd300);   // out-of-order feed
        query(32'd400);
    endtask

    task automatic test_gap_limit();
        feed(32'sd65536, 32'd1000);
        feed(-32'sd65536, 32'd2001);  // one tick wider than the reset gap
        query(32'd1500);
        feed(32'sd3, 32'd3001);       // exactly the gap
        query(32'd2500);
    endtask

    task automatic test_gap_extremes();
        drain_results();
        write_max_gap('0);
        feed(32'sd10, 32'd5000);
        query(32'd5000);
        query(32'd5001);
        drain_results();
        write_max_gap('1);
        feed(V_MIN, '0);
        feed(V_MAX, T_MAX);
        query(32'd1);
        query(T_MAX >> 1);
        query(T_MAX - 1);
        feed(V_MAX, '0);
        feed(V_MIN, T_MAX);   // full negative slope across the whole time range
        query(T_MAX >> 1);
        query(T_MAX - 1);
    endtask

    task automatic test_random_traffic(input int n_items, input logic [TB-1:0] span_max);
        int                   pick;
        logic signed [VB-1:0] value;
        logic [TB-1:0]        ts;
        logic [TB-1:0]        last_time;
        for (int i = 0; i < n_items; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 40 || !have_newer) begin
                last_time = have_newer ? newer_time : older_time;
                ts = (pick < 4) ? TB'($urandom()) : last_time + $urandom_range(1, span_max);
                case ($urandom_range(0, 3))
                    0:       value = $urandom();
                    1:       value = ($urandom_range(0, 1) != 0) ? V_MAX : V_MIN;
                    default: value = newer_value + VB'($urandom_range(0, 2047)) - VB'(1024);
                endcase
                feed(value, ts);
            end else if (pick < 80 && newer_time > older_time) begin
                query(TB'($urandom_range(older_time + 1, newer_time)));
            end else if (pick < 90) begin
                query(TB'($urandom()));
            end else if (pick < 95) begin
                query(older_time - TB'($urandom_range(0, 3)));
            end else begin
                query(newer_time + TB'($urandom_range(0, 3)));
            end
        end
    endtask

    initial begin
        aresetn        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        s_valid        = 1'b0;
        s_kind         = KIND_FEED;
        s_sample_value = '0;
        s_time_stamp   = '0;
        burst_mode     = 1'b0;
        fail_count     = 0;
        have_older     = 1'b0;
        have_newer     = 1'b0;
        older_value    = '0;
        newer_value    = '0;
        older_time     = '0;
        newer_time     = '0;
        gap_limit      = MAX_GAP_RESET[TB-1:0];
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_store();
        test_single_sample();
        test_span_cases();
        test_gap_limit();
        test_gap_extremes();

        drain_results();
        write_max_gap(32'd1000);
        test_random_traffic(310, 32'd1500);

        drain_results();
        write_max_gap($urandom_range(1, 100000));
        test_random_traffic(310, 2 * gap_limit);

        drain_results();
        write_max_gap('0);
        test_random_traffic(310, 32'd50);

        drain_results();
        write_max_gap('1);
        burst_mode = 1'b1;
        test_random_traffic(310, T_MAX >> 2);
        burst_mode = 1'b0;

        drain_results();
        write_max_gap($urandom_range(1, 16));
        test_random_traffic(310, 32'd32);

        drain_results();
        if (fail_count == 0) begin
            $display("two_point_sample_interpolator_tb OK");
        end else begin
            $display("two_point_sample_interpolator_tb NOT OK");
        end
        $finish;
    end

endmodule
